>>> hdl/byte_budget_lru_cache_macros.svh
// Assertion helpers for the cache table block
`ifndef BYTE_BUDGET_LRU_CACHE_MACROS_SVH
`define BYTE_BUDGET_LRU_CACHE_MACROS_SVH

// Check an implication on every clock edge outside reset
`define BBLC_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Check an implication in the following cycle
`define BBLC_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

>>> hdl/bblc_pkg.sv
package bblc_pkg;

   localparam int unsigned ENTRIES_DEFAULT = 16;
   localparam logic [31:0] BUDGET_RESET    = 32'd268435456;
   localparam logic [39:0] BYTES_MAX       = 40'hFF_FFFF_FFFF;
   localparam logic [7:0]  HOLD_MAX        = 8'd255;

   // Register indexes
   localparam logic CSR_BUDGET = 1'b0;
   localparam logic CSR_LOADER = 1'b1;

   // Actions
   localparam logic ACT_ACQUIRE = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   // Error codes
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_NO_LOADER = 2'd1;
   localparam logic [1:0] ERR_LOAD_FAIL = 2'd2;
   localparam logic [1:0] ERR_FULL      = 2'd3;

   typedef struct packed {
      logic        action;
      logic [15:0] frame_key;
      logic [31:0] load_bytes;
      logic        load_ok;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic        granted;
      logic [1:0]  error_code;
      logic [39:0] current_bytes;
      logic [39:0] peak_bytes;
      logic [4:0]  evictions;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_DECIDE,
      ST_SCAN,
      ST_EVICT,
      ST_INSERT,
      ST_RESPOND
   } state_type;

endpackage

>>> hdl/byte_budget_lru_cache.sv
// Keyed cache table with a byte budget and least-recently-used eviction.
// Input channel req_*: a transaction is taken when req_valid is high and
// req_stall is low. req_stall stays high from acceptance until the result
// is loaded into the output register, so one request is in progress at a time.
// Result channel rsp_*: one result per request, held in an output register
// until taken (rsp_valid high, rsp_stall low). While the receiver stalls the
// result is held; one further request may be taken and runs up to its own
// result, then waits with req_stall high until the held result is taken.
// Configuration csr_*: index 0 the byte budget, index 1 loader present;
// written when csr_valid and csr_ready are high; csr_ready is always high.
// Sequence: one lookup pass over all ENTRIES slots through a single key
// comparator, then for each eviction round a decide state, a scan of all
// slots through a single stamp comparator and an evict state that drops the
// victim. A hit, a release or a missing loader or failed load goes from
// decide to the respond state; a miss that is granted also passes through
// the insert state after its eviction rounds.
// Reset clears valid bits, the stamp clock and byte totals at once; the budget
// returns to 2^28 and the loader flag to one.
module byte_budget_lru_cache #(
   parameter int unsigned ENTRIES = bblc_pkg::ENTRIES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bblc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bblc_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [31:0]       csr_wdata
);

   localparam int unsigned IW = $clog2(ENTRIES);

   // Table storage
   logic [ENTRIES-1:0] valid_ff;
   logic [15:0] key_ff    [ENTRIES];
   logic [63:0] stamp_ff  [ENTRIES];
   logic [31:0] bytes_ff  [ENTRIES];
   logic [7:0]  holders_ff[ENTRIES];

   logic [63:0] clock_ff;
   logic [39:0] total_ff, total_in;
   logic [39:0] peak_ff, peak_in;
   logic [31:0] budget_ff;
   logic        loader_ff;

   bblc_pkg::state_type state_ff, state_in;
   bblc_pkg::req_type   req_ff;
   bblc_pkg::rsp_type   rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [IW-1:0] idx_ff, idx_in;
   logic          found_ff, found_in;
   logic [IW-1:0] slot_ff, slot_in;
   logic          best_ok_ff, best_ok_in;
   logic [IW-1:0] best_ff, best_in;
   logic [63:0]   best_stamp_ff, best_stamp_in;
   logic          free_ok_ff, free_ok_in;
   logic [IW-1:0] free_ff, free_in;
   logic          fullpass_ff, fullpass_in;
   logic [4:0]    evict_ff, evict_in;
   logic [1:0]    err_ff, err_in;
   logic          granted_ff, granted_in;

   logic          last_idx;
   logic [40:0]   need_sum;
   logic [39:0]   need;
   logic [39:0]   budget;
   logic          over;
   logic [39:0]   vbytes;
   logic [40:0]   add_sum;

   assign last_idx = (idx_ff == IW'(ENTRIES - 1));
   assign need     = (req_ff.load_bytes == 32'd0) ? 40'd1 : {8'd0, req_ff.load_bytes};
   assign budget   = (budget_ff == 32'd0) ? 40'd1 : {8'd0, budget_ff};
   // One adder/compare for the budget test; the insert total reuses its sum
   assign need_sum = {1'b0, total_ff} + {1'b0, need};
   assign over     = need_sum > {1'b0, budget};
   assign vbytes   = {8'd0, bytes_ff[best_ff]};
   assign add_sum  = need_sum;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bblc_pkg::ST_IDLE:    if (req_valid) state_in = bblc_pkg::ST_LOOKUP;
         bblc_pkg::ST_LOOKUP:  if (last_idx) state_in = bblc_pkg::ST_DECIDE;
         bblc_pkg::ST_DECIDE: begin
            if (req_ff.action == bblc_pkg::ACT_RELEASE || found_ff ||
                !loader_ff || !req_ff.load_ok)
               state_in = bblc_pkg::ST_RESPOND;
            else if (fullpass_ff)
               // Budget loop done: take a free slot or look for one more victim
               state_in = free_ok_ff ? bblc_pkg::ST_INSERT : bblc_pkg::ST_SCAN;
            else if (over || !free_ok_ff)
               state_in = bblc_pkg::ST_SCAN;
            else
               state_in = bblc_pkg::ST_INSERT;
         end
         bblc_pkg::ST_SCAN:    if (last_idx) state_in = bblc_pkg::ST_EVICT;
         bblc_pkg::ST_EVICT: begin
            if (!best_ok_ff)
               state_in = fullpass_ff ? bblc_pkg::ST_RESPOND : bblc_pkg::ST_DECIDE;
            else
               state_in = fullpass_ff ? bblc_pkg::ST_INSERT : bblc_pkg::ST_DECIDE;
         end
         bblc_pkg::ST_INSERT:  state_in = bblc_pkg::ST_RESPOND;
         bblc_pkg::ST_RESPOND: if (!rsp_valid_ff || !rsp_stall) state_in = bblc_pkg::ST_IDLE;
         default:              state_in = bblc_pkg::ST_IDLE;
      endcase
   end

   // Datapath control
   always_comb begin
      idx_in        = idx_ff;
      found_in      = found_ff;
      slot_in       = slot_ff;
      best_ok_in    = best_ok_ff;
      best_in       = best_ff;
      best_stamp_in = best_stamp_ff;
      free_ok_in    = free_ok_ff;
      free_in       = free_ff;
      fullpass_in   = fullpass_ff;
      evict_in      = evict_ff;
      err_in        = err_ff;
      granted_in    = granted_ff;
      total_in      = total_ff;
      peak_in       = peak_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      case (state_ff)
         bblc_pkg::ST_IDLE: begin
            idx_in     = '0;
            found_in   = 1'b0;
            free_ok_in = 1'b0;
            evict_in   = '0;
            err_in     = bblc_pkg::ERR_NONE;
            granted_in = 1'b0;
         end
         bblc_pkg::ST_LOOKUP: begin
            // Compare one slot per cycle; keep the first match and the first free slot
            if (valid_ff[idx_ff] && key_ff[idx_ff] == req_ff.frame_key && !found_ff) begin
               found_in = 1'b1;
               slot_in  = idx_ff;
            end
            if (!valid_ff[idx_ff] && !free_ok_ff) begin
               free_ok_in = 1'b1;
               free_in    = idx_ff;
            end
            idx_in = last_idx ? '0 : idx_ff + 1'b1;
         end
         bblc_pkg::ST_DECIDE: begin
            idx_in     = '0;
            best_ok_in = 1'b0;
            if (req_ff.action == bblc_pkg::ACT_RELEASE) begin
               err_in = bblc_pkg::ERR_NONE;
            end else if (found_ff) begin
               granted_in = 1'b1;
            end else if (!loader_ff) begin
               err_in = bblc_pkg::ERR_NO_LOADER;
            end else if (!req_ff.load_ok) begin
               err_in = bblc_pkg::ERR_LOAD_FAIL;
            end else begin
               // Once the budget loop has ended it stays ended
               fullpass_in = fullpass_ff || !over;
            end
         end
         bblc_pkg::ST_SCAN: begin
            // Track the oldest unpinned entry; ties keep the lower slot
            if (valid_ff[idx_ff] && holders_ff[idx_ff] == 8'd0 &&
                (!best_ok_ff || stamp_ff[idx_ff] < best_stamp_ff)) begin
               best_ok_in    = 1'b1;
               best_in       = idx_ff;
               best_stamp_in = stamp_ff[idx_ff];
            end
            idx_in = last_idx ? '0 : idx_ff + 1'b1;
         end
         bblc_pkg::ST_EVICT: begin
            if (best_ok_ff) begin
               total_in = (total_ff > vbytes) ? total_ff - vbytes : 40'd0;
               evict_in = evict_ff + 5'd1;
               // The freed slot becomes the lowest free one if lower
               if (!free_ok_ff || best_ff < free_ff) begin
                  free_ok_in = 1'b1;
                  free_in    = best_ff;
               end
            end else if (fullpass_ff) begin
               err_in = bblc_pkg::ERR_FULL;
            end else begin
               // Budget loop gave up: go to the free slot test
               fullpass_in = 1'b1;
            end
         end
         bblc_pkg::ST_INSERT: begin
            granted_in = 1'b1;
            total_in   = add_sum[40] ? bblc_pkg::BYTES_MAX : add_sum[39:0];
            if ((add_sum[40] ? bblc_pkg::BYTES_MAX : add_sum[39:0]) > peak_ff)
               peak_in = add_sum[40] ? bblc_pkg::BYTES_MAX : add_sum[39:0];
         end
         bblc_pkg::ST_RESPOND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in          = 1'b1;
               rsp_in.hit            = found_ff;
               rsp_in.granted        = granted_ff;
               rsp_in.error_code     = err_ff;
               rsp_in.current_bytes  = total_ff;
               rsp_in.peak_bytes     = peak_ff;
               rsp_in.evictions      = evict_ff;
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bblc_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         clock_ff     <= '0;
         total_ff     <= '0;
         peak_ff      <= '0;
         budget_ff    <= bblc_pkg::BUDGET_RESET;
         loader_ff    <= 1'b1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         peak_ff      <= peak_in;
         if (csr_valid && csr_index == bblc_pkg::CSR_BUDGET) budget_ff <= csr_wdata;
         if (csr_valid && csr_index == bblc_pkg::CSR_LOADER) loader_ff <= csr_wdata[0];
         if (state_ff == bblc_pkg::ST_EVICT && best_ok_ff) valid_ff[best_ff] <= 1'b0;
         if (state_ff == bblc_pkg::ST_INSERT) begin
            valid_ff[free_ff] <= 1'b1;
            clock_ff          <= clock_ff + 64'd1;
         end
         if (state_ff == bblc_pkg::ST_DECIDE && found_ff &&
             req_ff.action == bblc_pkg::ACT_ACQUIRE)
            clock_ff <= clock_ff + 64'd1;
      end
   end

   // Payload registers and table contents
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      found_ff      <= found_in;
      slot_ff       <= slot_in;
      best_ok_ff    <= best_ok_in;
      best_ff       <= best_in;
      best_stamp_ff <= best_stamp_in;
      free_ok_ff    <= free_ok_in;
      free_ff       <= free_in;
      fullpass_ff   <= (state_ff == bblc_pkg::ST_IDLE) ? 1'b0 : fullpass_in;
      evict_ff      <= evict_in;
      err_ff        <= err_in;
      granted_ff    <= granted_in;
      rsp_ff        <= rsp_in;
      if (state_ff == bblc_pkg::ST_IDLE && req_valid) req_ff <= req_data;
      if (state_ff == bblc_pkg::ST_DECIDE && found_ff) begin
         if (req_ff.action == bblc_pkg::ACT_RELEASE) begin
            if (holders_ff[slot_ff] != 8'd0) holders_ff[slot_ff] <= holders_ff[slot_ff] - 8'd1;
         end else begin
            stamp_ff[slot_ff] <= clock_ff + 64'd1;
            if (holders_ff[slot_ff] != bblc_pkg::HOLD_MAX)
               holders_ff[slot_ff] <= holders_ff[slot_ff] + 8'd1;
         end
      end
      if (state_ff == bblc_pkg::ST_INSERT) begin
         key_ff[free_ff]     <= req_ff.frame_key;
         stamp_ff[free_ff]   <= clock_ff + 64'd1;
         bytes_ff[free_ff]   <= need[31:0];
         holders_ff[free_ff] <= 8'd1;
      end
   end

   assign req_stall = (state_ff != bblc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

endmodule

>>> hdl/bblc_checker.sv
`include "byte_budget_lru_cache_macros.svh"

module bblc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input bblc_pkg::rsp_type rsp_data
);

   `BBLC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")
   `BBLC_ASSERT_IMPLY(a_grant_clean, clock, reset, rsp_valid && rsp_data.granted, rsp_data.error_code == bblc_pkg::ERR_NONE, "granted with error")
   `BBLC_ASSERT_IMPLY(a_peak, clock, reset, rsp_valid, rsp_data.current_bytes <= rsp_data.peak_bytes || rsp_data.evictions != 5'd0 || !rsp_data.granted, "current above peak")
   `BBLC_ASSERT_NEXT(a_busy, clock, reset, req_valid && !req_stall, req_stall, "took second request")

endmodule

bind byte_budget_lru_cache bblc_checker u_bblc_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);

>>> tb/sv/tb.sv
module tb;

   localparam int N = bblc_pkg::ENTRIES_DEFAULT;
   localparam longint unsigned CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   bblc_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   bblc_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = bblc_pkg::CSR_BUDGET;
   logic [31:0] csr_wdata = '0;

   byte_budget_lru_cache dut (.*);

   // Predictor state
   logic        slot_used [N];
   logic [15:0] slot_key [N];
   logic [63:0] slot_stamp [N];
   logic [31:0] slot_size [N];
   logic [7:0]  slot_holds [N];
   logic [63:0] stamp_clock;
   logic [39:0] bytes_now, bytes_peak;
   logic [31:0] budget_reg;
   logic        loader_reg;

   bblc_pkg::rsp_type expected_rsps [$];
   int mismatches = 0;
   bit quiet = 0;
   bit long_hold = 0;
   longint unsigned cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Abort on runaway
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      mismatches++;
   endtask

   function automatic int oldest_free_victim();
      int best;
      best = -1;
      for (int i = 0; i < N; i++)
         if (slot_used[i] && slot_holds[i] == 0 &&
             (best < 0 || slot_stamp[i] < slot_stamp[best]))
            best = i;
      return best;
   endfunction

   function automatic void drop_slot(input int s);
      logic [39:0] b;
      b = {8'd0, slot_size[s]};
      bytes_now = (bytes_now > b) ? bytes_now - b : '0;
      slot_used[s] = 1'b0;
   endfunction

   function automatic void clear_table();
      for (int i = 0; i < N; i++) begin
         slot_used[i] = '0; slot_key[i] = '0; slot_stamp[i] = '0;
         slot_size[i] = '0; slot_holds[i] = '0;
      end
      stamp_clock = '0; bytes_now = '0; bytes_peak = '0;
      budget_reg = bblc_pkg::BUDGET_RESET; loader_reg = 1'b1;
   endfunction

   // Work out the result of one transaction and advance the table
   function automatic bblc_pkg::rsp_type cache_outcome(input bblc_pkg::req_type r);
      bblc_pkg::rsp_type o;
      int s, v;
      logic [40:0] need, budget, sum;
      o = '0;
      s = -1;
      for (int i = 0; i < N; i++)
         if (s < 0 && slot_used[i] && slot_key[i] == r.frame_key) s = i;
      if (r.action == bblc_pkg::ACT_RELEASE) begin
         if (s >= 0) begin
            o.hit = 1'b1;
            if (slot_holds[s] > 0) slot_holds[s]--;
         end
      end else if (s >= 0) begin
         o.hit = 1'b1; o.granted = 1'b1;
         stamp_clock++;
         slot_stamp[s] = stamp_clock;
         if (slot_holds[s] < bblc_pkg::HOLD_MAX) slot_holds[s]++;
      end else if (!loader_reg) begin
         o.error_code = bblc_pkg::ERR_NO_LOADER;
      end else if (!r.load_ok) begin
         o.error_code = bblc_pkg::ERR_LOAD_FAIL;
      end else begin
         need = (r.load_bytes == 0) ? 41'd1 : {9'd0, r.load_bytes};
         budget = (budget_reg == 0) ? 41'd1 : {9'd0, budget_reg};
         while ({1'b0, bytes_now} + need > budget) begin
            v = oldest_free_victim();
            if (v < 0) break;
            drop_slot(v);
            o.evictions++;
         end
         s = -1;
         for (int i = 0; i < N; i++)
            if (s < 0 && !slot_used[i]) s = i;
         if (s < 0) begin
            v = oldest_free_victim();
            if (v >= 0) begin
               drop_slot(v);
               o.evictions++;
               s = v;
            end
         end
         if (s < 0) o.error_code = bblc_pkg::ERR_FULL;
         else begin
            stamp_clock++;
            slot_used[s] = 1'b1; slot_key[s] = r.frame_key;
            slot_stamp[s] = stamp_clock; slot_size[s] = need[31:0];
            slot_holds[s] = 8'd1;
            sum = {1'b0, bytes_now} + need;
            bytes_now = sum[40] ? bblc_pkg::BYTES_MAX : sum[39:0];
            if (bytes_now > bytes_peak) bytes_peak = bytes_now;
            o.granted = 1'b1;
         end
      end
      o.current_bytes = bytes_now;
      o.peak_bytes = bytes_peak;
      return o;
   endfunction

   // Receiver stall: random bursts, or a long hold-off on request
   initial begin
      int gap;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
            rsp_stall <= 1'b0;
            long_hold = 0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 6);
            rsp_stall <= 1'b1;
            repeat (gap - 1) @(negedge clock);
         end else
            rsp_stall <= 1'b0;
      end
   end

   // Check each result against the oldest expectation
   always @(posedge clock) begin
      bblc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0)
            report("unexpected result", 64'(rsp_data.current_bytes), 64'd0);
         else begin
            want = expected_rsps.pop_front();
            if (rsp_data.hit !== want.hit)
               report("hit", 64'(rsp_data.hit), 64'(want.hit));
            if (rsp_data.granted !== want.granted)
               report("granted", 64'(rsp_data.granted), 64'(want.granted));
            if (rsp_data.error_code !== want.error_code)
               report("error_code", 64'(rsp_data.error_code), 64'(want.error_code));
            if (rsp_data.current_bytes !== want.current_bytes)
               report("current_bytes", 64'(rsp_data.current_bytes),
                      64'(want.current_bytes));
            if (rsp_data.peak_bytes !== want.peak_bytes)
               report("peak_bytes", 64'(rsp_data.peak_bytes), 64'(want.peak_bytes));
            if (rsp_data.evictions !== want.evictions)
               report("evictions", 64'(rsp_data.evictions), 64'(want.evictions));
         end
      end
   end

   // Offer one transaction; valid stays high so the next one can follow at once
   task automatic send_request(input bblc_pkg::req_type r);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_rsps.push_back(cache_outcome(r));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (N * 20 + 40) @(negedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] val);
      wait_drained();
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == bblc_pkg::CSR_BUDGET) budget_reg = val;
      else loader_reg = val[0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic bblc_pkg::req_type make_req(input logic act, input logic [15:0] key,
                                                  input logic [31:0] sz, input logic ok);
      bblc_pkg::req_type r;
      r.action = act; r.frame_key = key; r.load_bytes = sz; r.load_ok = ok;
      return r;
   endfunction

   // Extremes of the fields and each special case
   task automatic test_directed();
      send_request(make_req(bblc_pkg::ACT_ACQUIRE, 16'hFFFF, 32'd0, 1'b1));
      send_request(make_req(bblc_pkg::ACT_ACQUIRE, 16'hFFFF, 32'd5, 1'b1));
      send_request(make_req(bblc_pkg::ACT_RELEASE, 16'hFFFF, 32'hFFFF_FFFF, 1'b0));
      send_request(make_req(bblc_pkg::ACT_RELEASE, 16'hFFFF, 32'd0, 1'b0));
      send_request(make_req(bblc_pkg::ACT_RELEASE, 16'hFFFF, 32'd0, 1'b0));
      send_request(make_req(bblc_pkg::ACT_RELEASE, 16'h1234, 32'd0, 1'b1));
      send_request(make_req(bblc_pkg::ACT_ACQUIRE, 16'h0000, 32'd7, 1'b0));
      write_csr(bblc_pkg::CSR_LOADER, 32'd0);
      send_request(make_req(bblc_pkg::ACT_ACQUIRE, 16'h0001, 32'd7, 1'b1));
      write_csr(bblc_pkg::CSR_LOADER, 32'hFFFF_FFFF);
      // zero budget acts as one: each new frame evicts the unpinned ones
      write_csr(bblc_pkg::CSR_BUDGET, 32'd0);
      send_request(make_req(bblc_pkg::ACT_ACQUIRE, 16'h0002, 32'hFFFF_FFFF, 1'b1));
      send_request(make_req(bblc_pkg::ACT_RELEASE, 16'h0002, 32'd0, 1'b0));
      send_request(make_req(bblc_pkg::ACT_ACQUIRE, 16'h0003, 32'hFFFF_FFFF, 1'b1));
      write_csr(bblc_pkg::CSR_BUDGET, 32'hFFFF_FFFF);
      // fill the table with pinned entries, then ask for one more
      for (int k = 0; k < N; k++)
         send_request(make_req(bblc_pkg::ACT_ACQUIRE, 16'(k) + 16'h0100,
                               32'hFFFF_FFFF, 1'b1));
      send_request(make_req(bblc_pkg::ACT_ACQUIRE, 16'h0200, 32'd3, 1'b1));
      // unpin the table again
      for (int k = 0; k < N; k++)
         send_request(make_req(bblc_pkg::ACT_RELEASE, 16'(k) + 16'h0100, 32'd0, 1'b0));
   endtask

   // Saturate one entry's holder count
   task automatic test_holder_saturation();
      quiet = 1;
      for (int k = 0; k < 258; k++)
         send_request(make_req(bblc_pkg::ACT_ACQUIRE, 16'h0100, 32'd0, 1'b1));
      for (int k = 0; k < 4; k++)
         send_request(make_req(bblc_pkg::ACT_RELEASE, 16'h0100, 32'd0, 1'b0));
      quiet = 0;
   endtask

   task automatic random_phase(input int count, input logic [15:0] keys);
      bblc_pkg::req_type r;
      for (int k = 0; k < count; k++) begin
         r.frame_key = 16'($urandom_range(0, keys));
         if ($urandom_range(0, 19) == 0) r.frame_key = 16'($urandom);
         r.action = ($urandom_range(0, 2) == 0) ? bblc_pkg::ACT_RELEASE :
                                                  bblc_pkg::ACT_ACQUIRE;
         case ($urandom_range(0, 3))
            0: r.load_bytes = $urandom;
            1: r.load_bytes = 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: r.load_bytes = $urandom_range(0, 64);
         endcase
         r.load_ok = ($urandom_range(0, 9) != 0);
         send_request(r);
      end
   endtask

   // Random traffic under several budgets
   task automatic test_random();
      write_csr(bblc_pkg::CSR_BUDGET, 32'd100);
      random_phase(45, 16'd40);
      write_csr(bblc_pkg::CSR_BUDGET, 32'd1);
      random_phase(20, 16'd20);
      write_csr(bblc_pkg::CSR_BUDGET, $urandom);
      random_phase(35, 16'd30);
      write_csr(bblc_pkg::CSR_LOADER, 32'd0);
      random_phase(10, 16'd30);
      write_csr(bblc_pkg::CSR_LOADER, 32'd1);
      write_csr(bblc_pkg::CSR_BUDGET, 32'hFFFF_FFFF);
      random_phase(30, 16'd25);
   endtask

   // Long receiver hold-off while requests keep coming, then a drained pause
   task automatic test_backpressure();
      write_csr(bblc_pkg::CSR_BUDGET, 32'd200);
      long_hold = 1;
      random_phase(20, 16'd30);
      wait_drained();
      random_phase(10, 16'd30);
      quiet = 1;
      random_phase(30, 16'd30);
   endtask

   initial begin
      clear_table();
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_holder_saturation();
      test_random();
      test_backpressure();
      wait_drained();
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
